// ----- hdl/ecd_pkg.sv -----
// Shared types, codes and default sizes for the Elias code decoder.
`timescale 1ns / 1ps
`default_nettype none

package ecd_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam int BYTE_WIDTH   = 8;
   localparam int RESULT_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 32;

   localparam logic [2:0] TOP_BIT = 3'd7;

   // Code selection.
   localparam logic [1:0] MODE_GAMMA = 2'd0;
   localparam logic [1:0] MODE_DELTA = 2'd1;
   localparam logic [1:0] MODE_OMEGA = 2'd2;

   // Decode phases: the leading run (or omega flag bit), then one or two fields.
   localparam logic [1:0] PHASE_LEAD   = 2'd0;
   localparam logic [1:0] PHASE_FIRST  = 2'd1;
   localparam logic [1:0] PHASE_SECOND = 2'd2;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] stream_byte;
      logic                  end_of_stream;
   } ecd_entry_type;

   typedef struct packed {
      logic [RESULT_WIDTH-1:0] decoded_value;
      logic                    overflow_error;
      logic                    last_of_byte;
   } ecd_result_type;

endpackage

`default_nettype wire

// ----- hdl/ecd_interfaces.sv -----
// Valid/ready channel interfaces for coded bytes and decoded results.
`timescale 1ns / 1ps
`default_nettype none

interface ecd_req_if;
   logic                          valid;
   logic                          ready;
   logic [ecd_pkg::BYTE_WIDTH-1:0] stream_byte;
   logic                          end_of_stream;

   modport source (output valid, output stream_byte, output end_of_stream, input ready);
   modport sink   (input valid, input stream_byte, input end_of_stream, output ready);
endinterface

interface ecd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [ecd_pkg::RESULT_WIDTH-1:0] decoded_value;
   logic                            overflow_error;
   logic                            last_of_byte;

   modport source (output valid, output decoded_value, output overflow_error,
                   output last_of_byte, input ready);
   modport sink   (input valid, input decoded_value, input overflow_error,
                   input last_of_byte, output ready);
endinterface

`default_nettype wire

// ----- hdl/ecd_front.sv -----
// Input side: accepts coded bytes into a short queue ahead of the bit decoder.
`timescale 1ns / 1ps
`default_nettype none

module ecd_front #(
   parameter int QUEUE_DEPTH = ecd_pkg::QUEUE_DEPTH_DEFAULT  // power of two, 2 or more
) (
   input  wire logic              clock,
   input  wire logic              reset,
   ecd_req_if.sink                req_chan,
   output ecd_pkg::ecd_entry_type head_entry,
   output logic                   head_valid,
   input  wire logic              pop
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

   ecd_pkg::ecd_entry_type slot_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          push;
   logic          pull;

   assign req_chan.ready = (count_ff != FULL_COUNT);
   assign push = req_chan.valid && req_chan.ready;
   assign pull = pop && head_valid;

   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pull ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pull) begin
         count_in = count_ff + 1'b1;
      end else if (pull && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{stream_byte: req_chan.stream_byte,
                                 end_of_stream: req_chan.end_of_stream};
      end
   end

   // The occupancy always matches the pointer distance.
   a_count_matches_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff != FULL_COUNT) |-> (PW'(count_ff) == PW'(wr_ptr_ff - rd_ptr_ff)))
      else $error("queue count disagrees with pointers");

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ----- hdl/ecd_back.sv -----
// Bit-serial Elias decoder: one stream bit per cycle unless stalled, results through a holding and output register.
`timescale 1ns / 1ps
`default_nettype none

module ecd_back #(
   parameter int VALUE_WIDTH = ecd_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [1:0]             code_mode,
   input  wire logic                   clear,
   input  wire logic                   head_valid,
   input  wire ecd_pkg::ecd_entry_type head_entry,
   output logic                        pop,
   ecd_rsp_if.source                   rsp_chan
);

   localparam int CW = $clog2(VALUE_WIDTH + 1);
   localparam int RUN_MAX = CW - 1;  // largest delta run with 2**run <= VALUE_WIDTH
   localparam logic [CW-1:0] VW_CNT = CW'(VALUE_WIDTH);
   localparam logic [CW-1:0] RUN_LIMIT = CW'(RUN_MAX);
   localparam logic [VALUE_WIDTH-1:0] VW_ACC = VALUE_WIDTH'(VALUE_WIDTH);
   localparam logic [VALUE_WIDTH-1:0] ACC_ONE = VALUE_WIDTH'(1);
   localparam logic [CW-1:0] CNT_ONE = CW'(1);

   // Byte being decoded.
   logic                             busy_ff, busy_in;
   logic [ecd_pkg::BYTE_WIDTH-1:0]   byte_ff;
   logic                             eos_ff;
   logic [2:0]                       bit_idx_ff, bit_idx_in;

   // Codeword state carried across bytes.
   logic [1:0]             phase_ff, phase_in;
   logic [CW-1:0]          run_ff, run_in;
   logic [CW-1:0]          flen_ff, flen_in;
   logic [CW-1:0]          left_ff, left_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;

   // One finished result is held back until we know whether it closes the byte.
   logic                   pend_v_ff, pend_v_in;
   ecd_pkg::ecd_result_type pend_ff, pend_in;
   logic                   flush_ff, flush_in;

   logic                   out_v_ff, out_v_in;
   ecd_pkg::ecd_result_type out_ff, out_in;

   logic                   b;
   logic                   last_bit;
   logic                   got;
   logic                   fin;
   logic                   fin_err;
   logic [VALUE_WIDTH-1:0] fin_val;
   logic [VALUE_WIDTH+ecd_pkg::RESULT_WIDTH-1:0] fin_ext;
   logic [CW-1:0]          run_n, left_n, flen_n;
   logic [VALUE_WIDTH-1:0] acc_n;
   logic                   out_free;
   logic                   need_out;
   logic                   advance;
   logic                   flush_go;
   logic                   byte_done;
   logic                   push;
   ecd_pkg::ecd_result_type new_res;

   assign b        = byte_ff[bit_idx_ff];
   assign last_bit = (bit_idx_ff == '0);
   assign run_n    = run_ff + CNT_ONE;
   assign left_n   = left_ff - CNT_ONE;
   assign flen_n   = {flen_ff[CW-2:0], b};
   assign acc_n    = {acc_ff[VALUE_WIDTH-2:0], b};

   // Next codeword state for the current bit.
   always_comb begin
      phase_in = phase_ff;
      run_in   = run_ff;
      flen_in  = flen_ff;
      left_in  = left_ff;
      acc_in   = acc_ff;
      fin      = 1'b0;
      fin_err  = 1'b0;
      fin_val  = ACC_ONE;
      case (code_mode)
         ecd_pkg::MODE_DELTA: begin
            if (phase_ff == ecd_pkg::PHASE_LEAD) begin
               if (!b) begin
                  run_in = run_n;
                  if (run_n > RUN_LIMIT) begin
                     fin = 1'b1;
                     fin_err = 1'b1;
                  end
               end else if (run_ff == '0) begin
                  fin = 1'b1;
               end else begin
                  flen_in  = CNT_ONE;
                  left_in  = run_ff;
                  phase_in = ecd_pkg::PHASE_FIRST;
               end
            end else if (phase_ff == ecd_pkg::PHASE_FIRST) begin
               flen_in = flen_n;
               left_in = left_n;
               if (left_n == '0) begin
                  if (flen_n > VW_CNT) begin
                     fin = 1'b1;
                     fin_err = 1'b1;
                  end else if (flen_n <= CNT_ONE) begin
                     fin = 1'b1;
                  end else begin
                     acc_in   = ACC_ONE;
                     left_in  = flen_n - CNT_ONE;
                     phase_in = ecd_pkg::PHASE_SECOND;
                  end
               end
            end else begin
               acc_in  = acc_n;
               left_in = left_n;
               if (left_n == '0) begin
                  fin = 1'b1;
                  fin_val = acc_n;
               end
            end
         end
         ecd_pkg::MODE_OMEGA: begin
            if (phase_ff == ecd_pkg::PHASE_LEAD) begin
               if (!b) begin
                  fin = 1'b1;
                  fin_val = acc_ff;
               end else if (acc_ff >= VW_ACC) begin
                  fin = 1'b1;
                  fin_err = 1'b1;
               end else begin
                  left_in  = acc_ff[CW-1:0];
                  acc_in   = ACC_ONE;
                  phase_in = ecd_pkg::PHASE_FIRST;
               end
            end else begin
               acc_in  = acc_n;
               left_in = left_n;
               if (left_n == '0) begin
                  phase_in = ecd_pkg::PHASE_LEAD;
               end
            end
         end
         default: begin
            // Gamma; the unused mode code decodes as gamma too.
            if (phase_ff == ecd_pkg::PHASE_LEAD) begin
               if (!b) begin
                  run_in = run_n;
                  if (run_n >= VW_CNT) begin
                     fin = 1'b1;
                     fin_err = 1'b1;
                  end
               end else if (run_ff == '0) begin
                  fin = 1'b1;
               end else begin
                  acc_in   = ACC_ONE;
                  left_in  = run_ff;
                  phase_in = ecd_pkg::PHASE_FIRST;
               end
            end else begin
               acc_in  = acc_n;
               left_in = left_n;
               if (left_n == '0) begin
                  fin = 1'b1;
                  fin_val = acc_n;
               end
            end
         end
      endcase
      if (fin) begin
         phase_in = ecd_pkg::PHASE_LEAD;
         run_in   = '0;
         flen_in  = '0;
         left_in  = '0;
         acc_in   = ACC_ONE;
      end
   end

   assign got     = fin;
   assign fin_ext = {{ecd_pkg::RESULT_WIDTH{1'b0}}, (fin_err ? '0 : fin_val)};
   assign new_res = '{decoded_value: fin_ext[ecd_pkg::RESULT_WIDTH-1:0],
                      overflow_error: fin_err,
                      last_of_byte: 1'b0};

   assign out_free = !out_v_ff || rsp_chan.ready;
   assign need_out = (got && pend_v_ff) || (last_bit && (got || pend_v_ff));
   assign advance  = busy_ff && !flush_ff && (!need_out || out_free);
   assign flush_go = busy_ff && flush_ff && out_free;
   assign byte_done = flush_go || (advance && last_bit && !(got && pend_v_ff));
   assign pop      = head_valid && (!busy_ff || byte_done);

   always_comb begin
      pend_v_in = pend_v_ff;
      pend_in   = pend_ff;
      flush_in  = flush_ff;
      push      = 1'b0;
      out_in    = out_ff;
      if (flush_go) begin
         push      = 1'b1;
         out_in    = pend_ff;
         out_in.last_of_byte = 1'b1;
         pend_v_in = 1'b0;
         flush_in  = 1'b0;
      end else if (advance) begin
         if (got && pend_v_ff) begin
            push      = 1'b1;
            out_in    = pend_ff;
            out_in.last_of_byte = 1'b0;
            pend_in   = new_res;
            flush_in  = last_bit;
         end else if (got && last_bit) begin
            push      = 1'b1;
            out_in    = new_res;
            out_in.last_of_byte = 1'b1;
         end else if (got) begin
            pend_v_in = 1'b1;
            pend_in   = new_res;
         end else if (last_bit && pend_v_ff) begin
            push      = 1'b1;
            out_in    = pend_ff;
            out_in.last_of_byte = 1'b1;
            pend_v_in = 1'b0;
         end
      end
      out_v_in = push ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_v_ff);
   end

   always_comb begin
      busy_in    = busy_ff;
      bit_idx_in = bit_idx_ff;
      if (pop) begin
         busy_in    = 1'b1;
         bit_idx_in = ecd_pkg::TOP_BIT;
      end else if (byte_done) begin
         busy_in = 1'b0;
      end else if (advance && !last_bit) begin
         bit_idx_in = bit_idx_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         bit_idx_ff <= ecd_pkg::TOP_BIT;
         pend_v_ff  <= 1'b0;
         flush_ff   <= 1'b0;
         out_v_ff   <= 1'b0;
      end else begin
         busy_ff    <= busy_in;
         bit_idx_ff <= bit_idx_in;
         pend_v_ff  <= pend_v_in;
         flush_ff   <= flush_in;
         out_v_ff   <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear || (advance && last_bit && eos_ff)) begin
         phase_ff <= ecd_pkg::PHASE_LEAD;
         run_ff   <= '0;
         flen_ff  <= '0;
         left_ff  <= '0;
         acc_ff   <= ACC_ONE;
      end else if (advance) begin
         phase_ff <= phase_in;
         run_ff   <= run_in;
         flen_ff  <= flen_in;
         left_ff  <= left_in;
         acc_ff   <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         byte_ff <= head_entry.stream_byte;
         eos_ff  <= head_entry.end_of_stream;
      end
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   assign rsp_chan.valid          = out_v_ff;
   assign rsp_chan.decoded_value  = out_ff.decoded_value;
   assign rsp_chan.overflow_error = out_ff.overflow_error;
   assign rsp_chan.last_of_byte   = out_ff.last_of_byte;

   a_flush_has_pending: assert property (@(posedge clock) disable iff (reset)
      flush_ff |-> (pend_v_ff && busy_ff))
      else $error("flush requested with no held result");

   a_error_value_zero: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && out_ff.overflow_error) |-> (out_ff.decoded_value == '0))
      else $error("overflow result carries a nonzero value");

   a_held_result_idle_free: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> !pend_v_ff)
      else $error("result held back after the byte finished");

   a_load_starts_top_bit: assert property (@(posedge clock) disable iff (reset)
      pop |=> (busy_ff && (bit_idx_ff == ecd_pkg::TOP_BIT)))
      else $error("new byte does not start at its top bit");

endmodule

`default_nettype wire

// ----- hdl/elias_code_decoder.sv -----
// Top level of the Elias gamma/delta/omega stream decoder with its register port.
//
// Usage: coded bytes enter on req_chan (valid/ready, stream_byte, end_of_stream);
// each byte is read most significant bit first. Every finished codeword leaves on
// rsp_chan as one transaction with decoded_value, overflow_error and last_of_byte,
// the latter set on the final result that a byte causes. A byte that finishes no
// codeword gives no transaction. code_mode (APB-style, byte address 0) picks gamma,
// delta or omega; writing it also clears any partial codeword. The user must see
// that it is written only while the block is idle; the block does not enforce it.
// Throughput: the decoder takes one stream bit per clock while rsp_chan lets its
// results out; when the final bit of a byte finishes a codeword while an earlier
// result of that byte is still held back, it delivers the earlier one and flushes
// the new one before taking the next byte. A byte queue of QUEUE_DEPTH entries
// (two by default) ahead of the decoder accepts new bytes while one is being decoded.
// A value needing more than VALUE_WIDTH bits gives an overflow transaction with
// value 0, and decoding restarts at the next bit. After an end_of_stream byte any
// unfinished codeword is dropped. Reset empties the queue and the output register
// and returns the mode to gamma. While rsp_chan is stalled the output register
// holds its transaction; the decoder runs on until it has a second result to
// deliver, and the queue then fills and lowers req_chan.ready.
`timescale 1ns / 1ps
`default_nettype none

module elias_code_decoder #(
   parameter int VALUE_WIDTH = ecd_pkg::VALUE_WIDTH_DEFAULT,  // 8 to 64
   parameter int QUEUE_DEPTH = ecd_pkg::QUEUE_DEPTH_DEFAULT   // power of two
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   ecd_req_if.sink                                   req_chan,
   ecd_rsp_if.source                                 rsp_chan,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [ecd_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  wire logic [ecd_pkg::CSR_DATA_WIDTH-1:0]   csr_pwdata,
   output logic      [ecd_pkg::CSR_DATA_WIDTH-1:0]   csr_prdata,
   output logic                                      csr_pready
);

   // With a single register every word address decodes to code_mode.
   logic                   mode_ff, mode_unused;
   logic [1:0]             code_mode_ff, code_mode_in;
   logic                   csr_write;
   logic                   head_valid;
   logic                   pop;
   ecd_pkg::ecd_entry_type head_entry;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // The byte offset within the word is don't-care for this register.
   assign mode_unused = ^csr_paddr;
   assign mode_ff     = mode_unused;

   assign code_mode_in = csr_write ? csr_pwdata[1:0] : code_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_mode_ff <= ecd_pkg::MODE_GAMMA;
      end else begin
         code_mode_ff <= code_mode_in;
      end
   end

   assign csr_prdata = {{(ecd_pkg::CSR_DATA_WIDTH-2){1'b0}}, code_mode_ff};

   // Front end: byte queue.
   ecd_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .head_entry (head_entry),
      .head_valid (head_valid),
      .pop        (pop)
   );

   // Back end: bit-serial decoder; a mode write clears its codeword state.
   ecd_back #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .code_mode  (code_mode_ff),
      .clear      (csr_write && (mode_ff || !mode_ff)),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

   a_mode_write_lands: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> (code_mode_ff == $past(csr_pwdata[1:0])))
      else $error("mode register missed a write");

   a_mode_holds: assert property (@(posedge clock) disable iff (reset)
      !csr_write |=> $stable(code_mode_ff))
      else $error("mode register changed without a write");

   a_pop_needs_data: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("decoder loaded from an empty queue");

endmodule

`default_nettype wire

// ----- verif/ecd_checker.sv -----
// Checker that predicts and compares the results of the Elias code decoder.
`timescale 1ns / 1ps
`default_nettype none

module ecd_checker
   import ecd_pkg::*;
#(
   parameter logic [CSR_ADDR_WIDTH-1:0] MODE_ADDR = '0
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   ecd_req_if                             req_mon,
   ecd_rsp_if                             rsp_mon,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   input  wire logic                      csr_pready,
   input  wire logic                      stream_drained,
   output int                             fail_count,
   output int                             words_pending,
   output int                             words_checked,
   output int                             overflows_checked
);

   localparam int VW = VALUE_WIDTH_DEFAULT;

   // Decoder state as the block holds it between bits and bytes.
   logic [1:0]     mode_q;
   logic [1:0]     phase_q;
   logic [5:0]     zero_run;
   logic [5:0]     len_field;
   logic [5:0]     bits_to_go;
   logic [63:0]    accum;
   ecd_result_type awaited_words[$];
   bit             drain_checked;

   task automatic report_mismatch(input string what);
      fail_count++;
      $display("[%0t] ERROR: %s", $time, what);
   endtask

   function automatic void clear_codeword();
      phase_q    = PHASE_LEAD;
      zero_run   = '0;
      len_field  = '0;
      bits_to_go = '0;
      accum      = 64'd1;
   endfunction

   function automatic logic close_word(input logic err, input logic [63:0] value,
                                       output ecd_result_type word);
      word.decoded_value  = err ? '0 : value[RESULT_WIDTH-1:0];
      word.overflow_error = err;
      word.last_of_byte   = 1'b0;
      clear_codeword();
      return 1'b1;
   endfunction

   // Shifts one stream bit into the decoder; returns 1 when a codeword ends.
   function automatic logic decode_bit(input logic b, output ecd_result_type word);
      word = '0;
      case (mode_q)
         MODE_DELTA: begin
            if (phase_q == PHASE_LEAD) begin
               if (!b) begin
                  zero_run = zero_run + 6'd1;
                  if ((64'd1 << zero_run) > 64'(VW)) return close_word(1'b1, 64'd0, word);
                  return 1'b0;
               end
               if (zero_run == 0) return close_word(1'b0, 64'd1, word);
               len_field  = 6'd1;
               bits_to_go = zero_run;
               phase_q    = PHASE_FIRST;
               return 1'b0;
            end
            if (phase_q == PHASE_FIRST) begin
               len_field  = {len_field[4:0], b};
               bits_to_go = bits_to_go - 6'd1;
               if (bits_to_go != 0) return 1'b0;
               if (len_field > VW) return close_word(1'b1, 64'd0, word);
               if (len_field <= 1) return close_word(1'b0, 64'd1, word);
               accum      = 64'd1;
               bits_to_go = len_field - 6'd1;
               phase_q    = PHASE_SECOND;
               return 1'b0;
            end
            accum      = {accum[62:0], b};
            bits_to_go = bits_to_go - 6'd1;
            if (bits_to_go == 0) return close_word(1'b0, accum, word);
            return 1'b0;
         end
         MODE_OMEGA: begin
            if (phase_q == PHASE_LEAD) begin
               // A zero flag ends the codeword; a one flag opens the next group.
               if (!b) return close_word(1'b0, accum, word);
               if (accum + 64'd1 > 64'(VW)) return close_word(1'b1, 64'd0, word);
               bits_to_go = accum[5:0];
               accum      = 64'd1;
               phase_q    = PHASE_FIRST;
               return 1'b0;
            end
            accum      = {accum[62:0], b};
            bits_to_go = bits_to_go - 6'd1;
            if (bits_to_go == 0) phase_q = PHASE_LEAD;
            return 1'b0;
         end
         default: begin
            // Gamma; the unused mode value decodes the same way.
            if (phase_q == PHASE_LEAD) begin
               if (!b) begin
                  zero_run = zero_run + 6'd1;
                  if (zero_run >= VW) return close_word(1'b1, 64'd0, word);
                  return 1'b0;
               end
               if (zero_run == 0) return close_word(1'b0, 64'd1, word);
               accum      = 64'd1;
               bits_to_go = zero_run;
               phase_q    = PHASE_FIRST;
               return 1'b0;
            end
            accum      = {accum[62:0], b};
            bits_to_go = bits_to_go - 6'd1;
            if (bits_to_go == 0) return close_word(1'b0, accum, word);
            return 1'b0;
         end
      endcase
   endfunction

   task automatic predict_byte(input logic [BYTE_WIDTH-1:0] code_byte, input logic eos);
      ecd_result_type word;
      int             made;
      made = 0;
      for (int i = TOP_BIT; i >= 0; i--) begin
         if (decode_bit(code_byte[i], word)) begin
            awaited_words.push_back(word);
            made++;
         end
      end
      if (made > 0) begin
         word = awaited_words.pop_back();
         word.last_of_byte = 1'b1;
         awaited_words.push_back(word);
      end
      if (eos) clear_codeword();
   endtask

   always @(posedge clock) begin
      ecd_result_type want;
      if (reset) begin
         mode_q = MODE_GAMMA;
         clear_codeword();
         awaited_words.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == MODE_ADDR) begin
            mode_q = csr_pwdata[1:0];
            clear_codeword();
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_byte(req_mon.stream_byte, req_mon.end_of_stream);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (awaited_words.size() == 0) begin
               report_mismatch($sformatf("unexpected result: value %h error %b last %b",
                  rsp_mon.decoded_value, rsp_mon.overflow_error, rsp_mon.last_of_byte));
            end else begin
               want = awaited_words.pop_front();
               words_checked++;
               if (want.overflow_error) overflows_checked++;
               if (rsp_mon.decoded_value !== want.decoded_value) begin
                  report_mismatch($sformatf("decoded_value %h, expected %h (result %0d)",
                     rsp_mon.decoded_value, want.decoded_value, words_checked));
               end
               if (rsp_mon.overflow_error !== want.overflow_error) begin
                  report_mismatch($sformatf("overflow_error %b, expected %b (result %0d)",
                     rsp_mon.overflow_error, want.overflow_error, words_checked));
               end
               if (rsp_mon.last_of_byte !== want.last_of_byte) begin
                  report_mismatch($sformatf("last_of_byte %b, expected %b (result %0d)",
                     rsp_mon.last_of_byte, want.last_of_byte, words_checked));
               end
            end
         end
         if (stream_drained && !drain_checked) begin
            drain_checked = 1'b1;
            if (awaited_words.size() != 0) begin
               report_mismatch($sformatf("%0d results never arrived", awaited_words.size()));
            end
         end
      end
      words_pending <= awaited_words.size();
   end

endmodule

`default_nettype wire

// ----- verif/tb_elias_code_decoder.sv -----
// Testbench top for the Elias code decoder: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps
`default_nettype none

module tb_elias_code_decoder;
   import ecd_pkg::*;

   localparam int CLOCK_PERIOD_NS = 20;
   localparam int RESET_CYCLES    = 12;
   localparam int ITEM_TARGET     = 270;
   localparam int PHASE_BYTES     = 40;
   // With one byte in the decoder and up to two more waiting in the queue, this
   // many quiet cycles cover bytes that finish no codeword.
   localparam int SETTLE_CYCLES   = 40;
   localparam int RUN_LIMIT_NS    = 30_000_000;

   localparam logic [CSR_ADDR_WIDTH-1:0] MODE_ADDR = '0;
   // The fourth encoding of the mode field has no code of its own.
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam logic [1:0] MODE_PLAN [7] = '{MODE_GAMMA, MODE_DELTA, MODE_OMEGA,
      MODE_SPARE, MODE_DELTA, MODE_GAMMA, MODE_OMEGA};

   typedef enum {PAD_ZEROS, PAD_ONES, PAD_RANDOM} pad_style_type;

   logic clock = 1'b0;
   logic reset;

   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   logic stream_drained;
   int   check_failures;
   int   results_pending;
   int   results_checked;
   int   overflow_results;

   // Stimulus bookkeeping.
   int bytes_sent;
   int mode_writes;
   int stall_left;
   bit quiet_link;   // when set, neither side inserts idle cycles
   bit coded_bits[$];

   ecd_req_if req_chan ();
   ecd_rsp_if rsp_chan ();

   elias_code_decoder i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   ecd_checker #(
      .MODE_ADDR (MODE_ADDR)
   ) i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_mon           (req_chan),
      .rsp_mon           (rsp_chan),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_pready        (csr_pready),
      .stream_drained    (stream_drained),
      .fail_count        (check_failures),
      .words_pending     (results_pending),
      .words_checked     (results_checked),
      .overflows_checked (overflow_results)
   );

   always #(CLOCK_PERIOD_NS / 2) clock = ~clock;

   // Idle stretches come from three ranges: mostly the shortest, sometimes the middle
   // one, and occasionally one long enough to back the decoder up into its input queue.
   function automatic int pick_idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return $urandom_range(1, 2);
      if (roll < 90) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   // The result side stalls at random unless the link is running quiet.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_chan.ready <= 1'b1;
         if (!quiet_link && $urandom_range(0, 99) < 20) stall_left = pick_idle_length();
      end
   end

   // Offers one byte and returns at the edge where it is taken. valid is left
   // high so that a following byte can go out back to back.
   task automatic send_byte(input logic [BYTE_WIDTH-1:0] code_byte, input logic eos);
      int gap;
      gap = (quiet_link || $urandom_range(0, 99) < 55) ? 0 : pick_idle_length();
      repeat (gap) begin
         req_chan.valid <= 1'b0;
         req_chan.stream_byte <= BYTE_WIDTH'($urandom());
         @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.stream_byte   <= code_byte;
      req_chan.end_of_stream <= eos;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      bytes_sent++;
   endtask

   // Holds the sender back until every predicted result has been delivered
   // and bytes that finish no codeword have drained out of the decoder.
   task automatic wait_until_idle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write: a setup phase, then an access phase that completes on pready.
   task automatic write_mode(input logic [1:0] mode);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= MODE_ADDR;
      csr_pwdata  <= CSR_DATA_WIDTH'(mode);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      mode_writes++;
   endtask

   function automatic int bit_length(input logic [63:0] value);
      int n;
      n = 0;
      for (int k = 0; k < 64; k++) begin
         if (value[k]) n = k + 1;
      end
      return n;
   endfunction

   function automatic void push_field(input logic [63:0] value, input int width);
      for (int k = width - 1; k >= 0; k--) coded_bits.push_back(value[k]);
   endfunction

   // Random value with exactly the given number of significant bits.
   function automatic logic [31:0] value_of_width(input int width);
      logic [63:0] mask;
      mask = (64'd1 << width) - 64'd1;
      return 32'(({32'd0, $urandom()} & mask) | (64'd1 << (width - 1)));
   endfunction

   // Small values dominate so that several codewords fit in a byte, but the
   // whole range up to the all-ones word is reached.
   function automatic logic [31:0] random_value();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 3) return 32'hFFFF_FFFF;
      if (roll < 43) return value_of_width($urandom_range(1, 4));
      if (roll < 78) return value_of_width($urandom_range(5, 16));
      return value_of_width($urandom_range(17, 32));
   endfunction

   // Omega groups from the outermost length down to the value itself; each
   // group starts with its own leading one, which the decoder takes as a flag.
   function automatic void push_omega_groups(input logic [31:0] value);
      logic [31:0] groups[$];
      logic [31:0] x;
      x = value;
      while (x > 1) begin
         groups.push_front(x);
         x = 32'(bit_length(64'(x)) - 1);
      end
      foreach (groups[g]) push_field(64'(groups[g]), bit_length(64'(groups[g])));
   endfunction

   function automatic void encode_word(input logic [1:0] mode, input logic [31:0] value);
      int width;
      int len_bits;
      width = bit_length(64'(value));
      case (mode)
         MODE_DELTA: begin
            len_bits = bit_length(64'(width));
            push_field(64'd0, len_bits - 1);
            push_field(64'(width), len_bits);
            push_field(64'(value), width - 1);
         end
         MODE_OMEGA: begin
            push_omega_groups(value);
            coded_bits.push_back(1'b0);
         end
         default: begin
            push_field(64'd0, width - 1);
            push_field(64'(value), width);
         end
      endcase
   endfunction

   // Codewords whose value cannot fit in 32 bits; delta has two kinds, the other codes one each.
   function automatic void encode_overflow(input logic [1:0] mode);
      case (mode)
         MODE_DELTA: begin
            if ($urandom_range(0, 1) == 0) begin
               push_field(64'd0, 6);
            end else begin
               push_field(64'd0, 5);
               push_field(64'($urandom_range(33, 63)), 6);
            end
         end
         MODE_OMEGA: begin
            push_omega_groups(value_of_width($urandom_range(6, 32)));
            coded_bits.push_back(1'b1);
         end
         default: push_field(64'd0, 32);
      endcase
   endfunction

   function automatic bit pad_bit(input pad_style_type style);
      case (style)
         PAD_ZEROS: return 1'b0;
         PAD_ONES:  return 1'b1;
         default:   return 1'($urandom());
      endcase
   endfunction

   // Sends every whole byte of the pending bit stream. When the stream ends
   // here, the tail is padded out and the last byte carries end_of_stream.
   task automatic flush_bits(input bit with_end, input pad_style_type style);
      logic [BYTE_WIDTH-1:0] next_byte;
      if (with_end) begin
         if (coded_bits.size() == 0) repeat (BYTE_WIDTH) coded_bits.push_back(pad_bit(style));
         while (coded_bits.size() % BYTE_WIDTH != 0) coded_bits.push_back(pad_bit(style));
      end
      while (coded_bits.size() >= BYTE_WIDTH) begin
         for (int k = 0; k < BYTE_WIDTH; k++) next_byte = {next_byte[6:0], coded_bits.pop_front()};
         send_byte(next_byte, with_end && coded_bits.size() == 0);
      end
   endtask

   // A run of well-formed codewords with random content, now and then an
   // oversized one. With cut_short the last codeword loses some or all of its bits
   // and the padded stream ends, so the decoder may have to drop an unfinished codeword.
   task automatic send_stream(input logic [1:0] mode, input int word_count,
                              input bit with_end, input bit cut_short);
      int last_start;
      int drop;
      last_start = 0;
      for (int w = 0; w < word_count; w++) begin
         last_start = coded_bits.size();
         if ($urandom_range(0, 9) == 0) encode_overflow(mode);
         else encode_word(mode, random_value());
      end
      if (cut_short) begin
         drop = $urandom_range(1, coded_bits.size() - last_start);
         repeat (drop) void'(coded_bits.pop_back());
      end
      flush_bits(with_end || cut_short, pad_style_type'($urandom_range(0, 2)));
   endtask

   initial begin
      int          phase;
      int          phase_end;
      int          roll;
      logic [1:0]  mode;

      // Every input gets a known value before the first clock edge; the result
      // side's ready is held low by its own process during reset.
      reset                  <= 1'b1;
      csr_psel               <= 1'b0;
      csr_penable            <= 1'b0;
      csr_pwrite             <= 1'b0;
      csr_paddr              <= MODE_ADDR;
      csr_pwdata             <= '0;
      req_chan.valid         <= 1'b0;
      req_chan.stream_byte   <= '0;
      req_chan.end_of_stream <= 1'b0;
      stream_drained         <= 1'b0;
      quiet_link              = 1'b0;
      bytes_sent              = 0;
      mode_writes             = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed checks, starting in gamma straight out of reset.
      // All ones: eight codewords of value 1, the most results one byte can give.
      send_byte(8'hFF, 1'b0);
      // Thirty-two zeros: the run overflows on the last one.
      repeat (4) send_byte(8'h00, 1'b0);
      // An unfinished run is dropped at end of stream; a lone one then decodes as 1.
      send_byte(8'h00, 1'b1);
      send_byte(8'h80, 1'b0);
      // The seven zeros that trail 0x80 are left open; the mode write must discard them.
      wait_until_idle();
      write_mode(MODE_DELTA);
      // Six zeros overflow the length prefix, then a one decodes as 1.
      send_byte(8'h02, 1'b1);
      // A length field of 33 overflows, then five ones decode as 1 each.
      send_byte(8'h04, 1'b0);
      send_byte(8'h3F, 1'b1);
      send_byte(8'hFF, 1'b1);
      wait_until_idle();
      write_mode(MODE_OMEGA);
      // Zero bits alone decode as 1 each, which is how padding behaves in omega.
      send_byte(8'h00, 1'b0);
      // Groups 2 and 4 and then a closing flag, followed by two more ones.
      send_byte(8'hA0, 1'b1);
      // Groups of 3, 15 and 65535; the next flag would need 65536 bits.
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFE, 1'b1);
      wait_until_idle();
      write_mode(MODE_SPARE);
      // The spare mode value must decode exactly like gamma.
      send_byte(8'hFF, 1'b1);
      send_byte(8'h40, 1'b1);

      // Random phases, each under one mode setting. Every third phase runs
      // without idle cycles on either side.
      phase = 0;
      while (bytes_sent < ITEM_TARGET) begin
         wait_until_idle();
         mode = MODE_PLAN[phase % 7];
         write_mode(mode);
         quiet_link = (phase % 3 == 2);
         phase_end = bytes_sent + PHASE_BYTES;
         while (bytes_sent < phase_end && bytes_sent < ITEM_TARGET) begin
            roll = $urandom_range(0, 99);
            if (roll < 72) begin
               send_stream(mode, $urandom_range(1, 6), $urandom_range(0, 3) != 0, 1'b0);
            end else if (roll < 84) begin
               send_stream(mode, $urandom_range(1, 3), 1'b1, 1'b1);
            end else if (roll < 96) begin
               // Noise: arbitrary bytes with the stream's bit carry left as it is.
               send_byte(BYTE_WIDTH'($urandom()), $urandom_range(0, 3) == 0);
            end else begin
               // The sender stops until the decoder has delivered everything.
               wait_until_idle();
            end
         end
         flush_bits(1'b1, pad_style_type'($urandom_range(0, 2)));
         quiet_link = 1'b0;
         phase++;
      end

      wait_until_idle();
      stream_drained <= 1'b1;
      repeat (2) @(posedge clock);

      $display("Sent %0d coded bytes over %0d mode settings, gamma through the spare code.",
               bytes_sent, mode_writes);
      $display("Checked %0d decoded results, %0d of them overflow transactions.",
               results_checked, overflow_results);
      if (check_failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Watchdog: a hung handshake ends the run.
   initial begin
      #(RUN_LIMIT_NS);
      $display("Simulation FAILED");
      $finish;
   end

endmodule

`default_nettype wire

// ----- sim.f -----
hdl/ecd_pkg.sv
hdl/ecd_interfaces.sv
hdl/ecd_front.sv
hdl/ecd_back.sv
hdl/elias_code_decoder.sv
verif/ecd_checker.sv
verif/tb_elias_code_decoder.sv
